### design/form_field_extract_url_decode_assert.svh
// assertion macros for the form field extractor checker
// clocked on i_clk; the reset-qualified form is disabled while i_rst_n is low
`ifndef FORM_FIELD_EXTRACT_URL_DECODE_ASSERT_SVH
`define FORM_FIELD_EXTRACT_URL_DECODE_ASSERT_SVH

// property checked only out of reset
`define FFEUD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define FFEUD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/ffeud_pkg.sv
// shared types, codes and helper functions of the form field extractor
// no dependencies
package ffeud_pkg;

    localparam int KEY_BYTES_DEF = 16;
    localparam int RUN_MAX       = 3;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [2:0] REG_KEY_LOW   = 3'd0;
    localparam logic [2:0] REG_KEY_HIGH  = 3'd1;
    localparam logic [2:0] REG_KEY_LEN   = 3'd2;
    localparam logic [2:0] REG_VAL_LIMIT = 3'd3;

    localparam logic [7:0] VAL_LIMIT_RST = 8'd32;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_SKIP  = 2'd1,
        MODE_VALUE = 2'd2,
        MODE_DONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_FOUND  = 2'd1,
        KIND_ABSENT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HEX1 = 2'd2
    } t_esc;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] vbyte;
        logic [7:0] vlen;
    } t_result;

    // results of one body byte, handed from the step logic to the output queue
    typedef struct packed {
        logic [1:0]            n;
        t_result [RUN_MAX-1:0] res;
    } t_run;

    // working copy of the value-side state while one byte is processed
    typedef struct packed {
        t_mode      mode;
        t_esc       esc;
        logic [7:0] cnt;
        t_run       run;
    } t_work;

    // {valid, nibble}
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] h;
        h = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            h = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            h = {1'b1, 4'(c - 8'h37)};
        end
        return h;
    endfunction

    function automatic t_work f_push(input t_work w, input t_kind k,
                                     input logic [7:0] b, input logic [7:0] l);
        t_work r;
        r = w;
        if (r.run.n != 2'd3) begin
            r.run.res[r.run.n].kind  = k;
            r.run.res[r.run.n].vbyte = b;
            r.run.res[r.run.n].vlen  = l;
            r.run.n = r.run.n + 2'd1;
        end
        return r;
    endfunction

    function automatic t_work f_finish(input t_work w);
        t_work r;
        r = f_push(w, KIND_FOUND, 8'd0, w.cnt);
        r.mode = MODE_DONE;
        r.esc  = ESC_NONE;
        return r;
    endfunction

    function automatic t_work f_emit(input t_work w, input logic [7:0] b,
                                     input logic [7:0] limit);
        t_work r;
        r = f_push(w, KIND_BYTE, b, 8'd0);
        r.cnt = r.cnt + 8'd1;
        if (r.cnt >= limit) begin
            r = f_finish(r);
        end
        return r;
    endfunction

    // value byte with no escape pending
    function automatic t_work f_plain(input t_work w, input logic [7:0] c,
                                      input logic [7:0] limit);
        t_work r;
        r = w;
        if (c == 8'd0 || c == CH_AMP) begin
            r = f_finish(r);
        end else if (c == CH_PERCENT) begin
            r.esc = ESC_PCT;
        end else if (c == CH_PLUS) begin
            r = f_emit(r, CH_SPACE, limit);
        end else begin
            r = f_emit(r, c, limit);
        end
        return r;
    endfunction

endpackage

### design/ffeud_core.sv
// parse state registers and the per-byte step logic of the form field extractor
// depends on ffeud_pkg
module ffeud_core #(
    parameter int KEY_BYTES = ffeud_pkg::KEY_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_byte,
    input  logic                   i_eob,
    input  logic [KEY_BYTES*8-1:0] i_key,
    input  logic [4:0]             i_key_len,
    input  logic [7:0]             i_limit,
    output ffeud_pkg::t_run        o_run
);

    ffeud_pkg::t_mode r_mode;
    ffeud_pkg::t_esc  r_esc;
    logic [4:0]       r_kpos;
    logic             r_keq;
    logic [7:0]       r_fhc;
    logic [7:0]       r_cnt;

    ffeud_pkg::t_work w;
    logic [4:0]       n_kpos;
    logic             n_keq;
    logic [7:0]       n_fhc;
    logic [4:0]       klen;
    logic [7:0]       ksel;
    logic [4:0]       hc;
    logic [4:0]       hf;

    assign klen = (i_key_len > 5'(KEY_BYTES)) ? 5'(KEY_BYTES) : i_key_len;
    assign hc   = ffeud_pkg::f_hex(i_byte);
    assign hf   = ffeud_pkg::f_hex(r_fhc);

    always_comb begin
        ksel = 8'd0;
        for (int j = 0; j < KEY_BYTES; j++) begin
            if (r_kpos == 5'(j)) begin
                ksel = i_key[8*j +: 8];
            end
        end
    end

    // next state and the results of this byte
    always_comb begin
        w        = '0;
        w.mode   = r_mode;
        w.esc    = r_esc;
        w.cnt    = r_cnt;
        n_kpos   = r_kpos;
        n_keq    = r_keq;
        n_fhc    = r_fhc;
        case (r_mode)
            ffeud_pkg::MODE_KEY: begin
                if (i_byte == 8'd0) begin
                    w = ffeud_pkg::f_push(w, ffeud_pkg::KIND_ABSENT, 8'd0, 8'd0);
                    w.mode = ffeud_pkg::MODE_DONE;
                end else if (i_byte == ffeud_pkg::CH_EQUAL) begin
                    if (r_keq && r_kpos == klen) begin
                        w.mode = ffeud_pkg::MODE_VALUE;
                        w.cnt  = 8'd0;
                        w.esc  = ffeud_pkg::ESC_NONE;
                        if (i_limit == 8'd0) begin
                            w = ffeud_pkg::f_finish(w);
                        end
                    end else begin
                        w.mode = ffeud_pkg::MODE_SKIP;
                    end
                end else begin
                    if (r_kpos >= klen || ksel != i_byte) begin
                        n_keq = 1'b0;
                    end
                    if (r_kpos < 5'd31) begin
                        n_kpos = r_kpos + 5'd1;
                    end
                end
            end
            ffeud_pkg::MODE_SKIP: begin
                if (i_byte == 8'd0) begin
                    w = ffeud_pkg::f_push(w, ffeud_pkg::KIND_ABSENT, 8'd0, 8'd0);
                    w.mode = ffeud_pkg::MODE_DONE;
                end else if (i_byte == ffeud_pkg::CH_AMP) begin
                    w.mode = ffeud_pkg::MODE_KEY;
                    n_kpos = 5'd0;
                    n_keq  = 1'b1;
                end
            end
            ffeud_pkg::MODE_VALUE: begin
                case (r_esc)
                    ffeud_pkg::ESC_NONE: begin
                        w = ffeud_pkg::f_plain(w, i_byte, i_limit);
                    end
                    ffeud_pkg::ESC_PCT: begin
                        if (hc[4]) begin
                            n_fhc = i_byte;
                            w.esc = ffeud_pkg::ESC_HEX1;
                        end else begin
                            w.esc = ffeud_pkg::ESC_NONE;
                            w = ffeud_pkg::f_emit(w, ffeud_pkg::CH_PERCENT, i_limit);
                            if (w.mode == ffeud_pkg::MODE_VALUE) begin
                                w = ffeud_pkg::f_plain(w, i_byte, i_limit);
                            end
                        end
                    end
                    default: begin
                        w.esc = ffeud_pkg::ESC_NONE;
                        if (hf[4] && hc[4]) begin
                            w = ffeud_pkg::f_emit(w, {hf[3:0], hc[3:0]}, i_limit);
                        end else begin
                            w = ffeud_pkg::f_emit(w, ffeud_pkg::CH_PERCENT, i_limit);
                            if (w.mode == ffeud_pkg::MODE_VALUE) begin
                                w = ffeud_pkg::f_emit(w, r_fhc, i_limit);
                            end
                            if (w.mode == ffeud_pkg::MODE_VALUE) begin
                                // at end of body the stray byte is dropped
                                if (i_eob && i_byte != 8'd0 && i_byte != ffeud_pkg::CH_AMP) begin
                                    w = ffeud_pkg::f_finish(w);
                                end else begin
                                    w = ffeud_pkg::f_plain(w, i_byte, i_limit);
                                end
                            end
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (i_eob) begin
            if (w.mode == ffeud_pkg::MODE_KEY || w.mode == ffeud_pkg::MODE_SKIP) begin
                w = ffeud_pkg::f_push(w, ffeud_pkg::KIND_ABSENT, 8'd0, 8'd0);
            end else if (w.mode == ffeud_pkg::MODE_VALUE) begin
                // flush a pending escape as literal bytes
                if (w.esc != ffeud_pkg::ESC_NONE) begin
                    w = ffeud_pkg::f_emit(w, ffeud_pkg::CH_PERCENT, i_limit);
                    if (w.mode == ffeud_pkg::MODE_VALUE && w.esc == ffeud_pkg::ESC_HEX1) begin
                        w = ffeud_pkg::f_emit(w, n_fhc, i_limit);
                    end
                end
                if (w.mode == ffeud_pkg::MODE_VALUE) begin
                    w = ffeud_pkg::f_finish(w);
                end
            end
            w.mode = ffeud_pkg::MODE_KEY;
            w.esc  = ffeud_pkg::ESC_NONE;
            w.cnt  = 8'd0;
            n_kpos = 5'd0;
            n_keq  = 1'b1;
            n_fhc  = 8'd0;
        end
    end

    assign o_run = w.run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ffeud_pkg::MODE_KEY;
            r_esc  <= ffeud_pkg::ESC_NONE;
            r_kpos <= 5'd0;
            r_keq  <= 1'b1;
            r_fhc  <= 8'd0;
            r_cnt  <= 8'd0;
        end else if (i_fire) begin
            r_mode <= w.mode;
            r_esc  <= w.esc;
            r_kpos <= n_kpos;
            r_keq  <= n_keq;
            r_fhc  <= n_fhc;
            r_cnt  <= w.cnt;
        end
    end

endmodule

### design/ffeud_outq.sv
// result register of the form field extractor: holds up to three results
// of a body byte and hands them out one transfer at a time; depends on ffeud_pkg
module ffeud_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ffeud_pkg::t_run i_run,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output ffeud_pkg::t_result o_res,
    output logic            o_last
);

    logic [1:0]                             r_left;
    logic [1:0]                             r_idx;
    ffeud_pkg::t_result [ffeud_pkg::RUN_MAX-1:0] r_res;
    logic                                   pop;

    assign o_valid = (r_left != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_free  = (r_left == 2'd0) || (r_left == 2'd1 && pop);
    assign o_res   = r_res[r_idx];
    assign o_last  = (r_left == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_left <= i_run.n;
            r_idx  <= 2'd0;
        end else if (pop) begin
            r_left <= r_left - 2'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_run.res;
        end
    end

endmodule

### design/form_field_extract_url_decode.sv
// path: an input transfer passes the input register, then the result register,
// before its first result transfer
// throughput: one body byte per cycle while the output is ready; a byte with two
// or three results holds the input register while the result register drains
// reset: synchronous, active low; clears parse state, queue and key; limit to 32
module form_field_extract_url_decode #(
    parameter int KEY_BYTES = ffeud_pkg::KEY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // body_byte
    input  logic        i_s_tlast,   // end_of_body
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // value_byte [7:0], value_length [15:8]
    output logic [1:0]  o_m_tuser,   // result_kind
    output logic        o_m_tlast,   // last_of_run
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_eob;
    logic [KEY_BYTES*8-1:0] r_key;
    logic [4:0]             r_key_len;
    logic [7:0]             r_limit;

    logic                   fire;
    logic                   q_free;
    logic                   cfg_we;
    ffeud_pkg::t_run        run;
    ffeud_pkg::t_result     res;

    assign fire        = r_in_valid && q_free;
    assign o_s_tready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_eob  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_key_len <= 5'd0;
            r_limit   <= ffeud_pkg::VAL_LIMIT_RST;
        end else if (cfg_we) begin
            for (int j = 0; j < KEY_BYTES; j++) begin
                if (j < 8 && i_cfg_index == ffeud_pkg::REG_KEY_LOW) begin
                    r_key[8*j +: 8] <= i_cfg_data[8*(j & 7) +: 8];
                end
                if (j >= 8 && i_cfg_index == ffeud_pkg::REG_KEY_HIGH) begin
                    r_key[8*j +: 8] <= i_cfg_data[8*(j & 7) +: 8];
                end
            end
            if (i_cfg_index == ffeud_pkg::REG_KEY_LEN) begin
                r_key_len <= i_cfg_data[4:0];
            end
            if (i_cfg_index == ffeud_pkg::REG_VAL_LIMIT) begin
                r_limit <= i_cfg_data[7:0];
            end
        end
    end

    ffeud_core #(
        .KEY_BYTES (KEY_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .i_eob     (r_in_eob),
        .i_key     (r_key),
        .i_key_len (r_key_len),
        .i_limit   (r_limit),
        .o_run     (run)
    );

    ffeud_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_run   (run),
        .o_free  (q_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {res.vlen, res.vbyte};
    assign o_m_tuser = res.kind;

endmodule

### design/ffeud_chk.sv
// port-level checker of the form field extractor and its bind to the top level
// depends on ffeud_pkg and form_field_extract_url_decode_assert.svh
`include "form_field_extract_url_decode_assert.svh"

module ffeud_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // a stalled result keeps its payload
    `FFEUD_ASSERT(a_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled result changed")

    // closing results end the run
    `FFEUD_ASSERT(a_close_last, o_m_tvalid && o_m_tuser != ffeud_pkg::KIND_BYTE |-> o_m_tlast && o_m_tdata[7:0] == 8'd0, "closing result not last or carries a byte")

    // value bytes carry no length
    `FFEUD_ASSERT(a_byte_len, o_m_tvalid && o_m_tuser == ffeud_pkg::KIND_BYTE |-> o_m_tdata[15:8] == 8'd0, "value byte with nonzero length")

    // nothing leaves the block right after reset
    `FFEUD_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind form_field_extract_url_decode ffeud_chk u_chk (.*);

### tb/form_field_extract_url_decode_tb.sv
// self-checking bench for form_field_extract_url_decode: directed rows, then random form bodies
// keeps its own model of key matching and percent decoding; needs ffeud_pkg and the block
module form_field_extract_url_decode_tb;

    localparam int         SETTLE_CYCLES = 6;
    localparam int         RANDOM_ITEMS  = 360;
    localparam logic [2:0] REG_NONE      = 3'd7;

    typedef struct {
        ffeud_pkg::t_kind kind;
        logic [7:0]       vbyte;
        logic [7:0]       vlen;
        logic             last;
    } t_field_result;

    typedef struct {
        logic             is_cfg;
        logic [2:0]       index;
        logic [63:0]      data;
        logic [7:0]       body_byte;
        logic             body_end;
        logic             typed;
        ffeud_pkg::t_kind kind;
        logic [7:0]       vbyte;
        logic [7:0]       vlen;
    } t_plan_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [63:0] cfg_data  = 64'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_ready;

    // extractor model state and its copy of the registers
    ffeud_pkg::t_mode parse_mode;
    logic [4:0]       key_pos;
    logic             key_equal;
    ffeud_pkg::t_esc  esc_stage;
    logic [7:0]       hex_first;
    logic [7:0]       value_count;
    logic [63:0]      key_lo_reg;
    logic [63:0]      key_hi_reg;
    logic [4:0]       key_len_reg;
    logic [7:0]       limit_reg;

    t_field_result byte_results[$];
    t_field_result pending_results[$];
    logic [7:0]    body_q[$];
    int            fail_count = 0;
    int            sent_items = 0;
    logic          in_quiet   = 1'b0;

    form_field_extract_url_decode dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] key_at(input int idx);
        if (idx < 8) return key_lo_reg[8*idx +: 8];
        if (idx < 16) return key_hi_reg[8*(idx-8) +: 8];
        return 8'd0;
    endfunction

    task automatic clear_parse();
        parse_mode  = ffeud_pkg::MODE_KEY;
        key_pos     = 5'd0;
        key_equal   = 1'b1;
        esc_stage   = ffeud_pkg::ESC_NONE;
        hex_first   = 8'd0;
        value_count = 8'd0;
    endtask

    task automatic reset_extractor();
        key_lo_reg  = 64'd0;
        key_hi_reg  = 64'd0;
        key_len_reg = 5'd0;
        limit_reg   = ffeud_pkg::VAL_LIMIT_RST;
        clear_parse();
    endtask

    // a byte carries at most three results, extra ones are lost
    task automatic add_result(input ffeud_pkg::t_kind kind, input logic [7:0] vbyte,
                              input logic [7:0] vlen);
        t_field_result r;
        if (byte_results.size() < ffeud_pkg::RUN_MAX) begin
            r.kind  = kind;
            r.vbyte = vbyte;
            r.vlen  = vlen;
            r.last  = 1'b0;
            byte_results.push_back(r);
        end
    endtask

    task automatic close_field();
        add_result(ffeud_pkg::KIND_FOUND, 8'd0, value_count);
        parse_mode = ffeud_pkg::MODE_DONE;
        esc_stage  = ffeud_pkg::ESC_NONE;
    endtask

    task automatic emit_value(input logic [7:0] b);
        add_result(ffeud_pkg::KIND_BYTE, b, 8'd0);
        value_count = value_count + 8'd1;
        if (value_count >= limit_reg) close_field();
    endtask

    task automatic plain_value(input logic [7:0] c);
        if (c == 8'd0 || c == ffeud_pkg::CH_AMP) close_field();
        else if (c == ffeud_pkg::CH_PERCENT) esc_stage = ffeud_pkg::ESC_PCT;
        else if (c == ffeud_pkg::CH_PLUS) emit_value(ffeud_pkg::CH_SPACE);
        else emit_value(c);
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic eob);
        int              klen;
        int              hi;
        int              lo;
        ffeud_pkg::t_esc held;
        byte_results.delete();
        klen = (int'(key_len_reg) > ffeud_pkg::KEY_BYTES_DEF) ?
               ffeud_pkg::KEY_BYTES_DEF : int'(key_len_reg);
        case (parse_mode)
            ffeud_pkg::MODE_KEY: begin
                if (c == 8'd0) begin
                    add_result(ffeud_pkg::KIND_ABSENT, 8'd0, 8'd0);
                    parse_mode = ffeud_pkg::MODE_DONE;
                end else if (c == ffeud_pkg::CH_EQUAL) begin
                    if (key_equal && int'(key_pos) == klen) begin
                        parse_mode  = ffeud_pkg::MODE_VALUE;
                        value_count = 8'd0;
                        esc_stage   = ffeud_pkg::ESC_NONE;
                        if (limit_reg == 8'd0) close_field();
                    end else begin
                        parse_mode = ffeud_pkg::MODE_SKIP;
                    end
                end else begin
                    if (int'(key_pos) >= klen || key_at(int'(key_pos)) != c) key_equal = 1'b0;
                    if (key_pos != 5'd31) key_pos = key_pos + 5'd1;
                end
            end
            ffeud_pkg::MODE_SKIP: begin
                if (c == 8'd0) begin
                    add_result(ffeud_pkg::KIND_ABSENT, 8'd0, 8'd0);
                    parse_mode = ffeud_pkg::MODE_DONE;
                end else if (c == ffeud_pkg::CH_AMP) begin
                    parse_mode = ffeud_pkg::MODE_KEY;
                    key_pos    = 5'd0;
                    key_equal  = 1'b1;
                end
            end
            ffeud_pkg::MODE_VALUE: begin
                if (esc_stage == ffeud_pkg::ESC_NONE) begin
                    plain_value(c);
                end else if (esc_stage == ffeud_pkg::ESC_PCT) begin
                    if (hex_nibble(c) >= 0) begin
                        hex_first = c;
                        esc_stage = ffeud_pkg::ESC_HEX1;
                    end else begin
                        esc_stage = ffeud_pkg::ESC_NONE;
                        emit_value(ffeud_pkg::CH_PERCENT);
                        if (parse_mode == ffeud_pkg::MODE_VALUE) plain_value(c);
                    end
                end else begin
                    hi = hex_nibble(hex_first);
                    lo = hex_nibble(c);
                    esc_stage = ffeud_pkg::ESC_NONE;
                    if (hi >= 0 && lo >= 0) begin
                        emit_value(8'(hi * 16 + lo));
                    end else begin
                        emit_value(ffeud_pkg::CH_PERCENT);
                        if (parse_mode == ffeud_pkg::MODE_VALUE) emit_value(hex_first);
                        // broken escape on the last byte: that byte is dropped
                        if (parse_mode == ffeud_pkg::MODE_VALUE) begin
                            if (eob && c != 8'd0 && c != ffeud_pkg::CH_AMP) close_field();
                            else plain_value(c);
                        end
                    end
                end
            end
            default: ;
        endcase
        if (eob) begin
            if (parse_mode == ffeud_pkg::MODE_KEY || parse_mode == ffeud_pkg::MODE_SKIP) begin
                add_result(ffeud_pkg::KIND_ABSENT, 8'd0, 8'd0);
            end else if (parse_mode == ffeud_pkg::MODE_VALUE) begin
                // a pending escape flushes as literal bytes
                held      = esc_stage;
                esc_stage = ffeud_pkg::ESC_NONE;
                if (held != ffeud_pkg::ESC_NONE) emit_value(ffeud_pkg::CH_PERCENT);
                if (held == ffeud_pkg::ESC_HEX1 && parse_mode == ffeud_pkg::MODE_VALUE)
                    emit_value(hex_first);
                if (parse_mode == ffeud_pkg::MODE_VALUE) close_field();
            end
            clear_parse();
        end
        if (byte_results.size() != 0) byte_results[byte_results.size()-1].last = 1'b1;
    endtask

    function automatic t_plan_row byte_row(input logic [7:0] b, input logic eob);
        t_plan_row row;
        row = '{is_cfg: 1'b0, index: 3'd0, data: 64'd0, body_byte: b, body_end: eob,
                typed: 1'b0, kind: ffeud_pkg::KIND_BYTE, vbyte: 8'd0, vlen: 8'd0};
        return row;
    endfunction

    function automatic t_plan_row byte_exp(input logic [7:0] b, input logic eob,
                                           input ffeud_pkg::t_kind kind,
                                           input logic [7:0] vbyte,
                                           input logic [7:0] vlen);
        t_plan_row row;
        row       = byte_row(b, eob);
        row.typed = 1'b1;
        row.kind  = kind;
        row.vbyte = vbyte;
        row.vlen  = vlen;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(input logic [2:0] index, input logic [63:0] data);
        t_plan_row row;
        row        = byte_row(8'd0, 1'b0);
        row.is_cfg = 1'b1;
        row.index  = index;
        row.data   = data;
        return row;
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            ffeud_pkg::REG_KEY_LOW:   key_lo_reg  = value;
            ffeud_pkg::REG_KEY_HIGH:  key_hi_reg  = value;
            ffeud_pkg::REG_KEY_LEN:   key_len_reg = value[4:0];
            ffeud_pkg::REG_VAL_LIMIT: limit_reg   = value[7:0];
            default: ;
        endcase
    endtask

    task automatic send_byte(input t_plan_row row);
        t_field_result r;
        int            gap;
        gap = in_quiet ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.body_byte;
        s_tlast  <= row.body_end;
        do begin
            @(posedge clk);
        end while (!s_tready);
        predict_byte(row.body_byte, row.body_end);
        sent_items++;
        if (row.typed) begin
            r.kind  = row.kind;
            r.vbyte = row.vbyte;
            r.vlen  = row.vlen;
            r.last  = 1'b1;
            pending_results.push_back(r);
        end else begin
            foreach (byte_results[k]) pending_results.push_back(byte_results[k]);
        end
    endtask

    function automatic logic [7:0] pick_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'h30 + 8'(r);
        if (r < 16) return 8'h61 + 8'(r - 10);
        return 8'h41 + 8'(r - 16);
    endfunction

    // never a hex digit, a zero or an ampersand
    function automatic logic [7:0] pick_nonhex();
        case ($urandom_range(0, 4))
            0:       return 8'h67 + 8'($urandom_range(0, 19));
            1:       return 8'h47 + 8'($urandom_range(0, 19));
            2:       return ffeud_pkg::CH_PLUS;
            3:       return ffeud_pkg::CH_PERCENT;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_key_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0, 1:    c = 8'h61 + 8'($urandom_range(0, 25));
            2:       c = 8'h30 + 8'($urandom_range(0, 9));
            3:       c = ffeud_pkg::CH_AMP;
            default: c = 8'($urandom_range(1, 255));
        endcase
        if (c == ffeud_pkg::CH_EQUAL) c = 8'h5f;
        return c;
    endfunction

    task automatic pick_settings();
        logic [63:0] v;
        int          r;
        for (int w = 0; w < 2; w++) begin
            if ($urandom_range(0, 3) != 0) begin
                for (int k = 0; k < 8; k++) v[8*k +: 8] = pick_key_char();
                r = $urandom_range(0, 11);
                if (r == 0) v = {$urandom(), $urandom()};
                else if (r == 1) v = '1;
                else if (r == 2) v = '0;
                write_reg(w == 0 ? ffeud_pkg::REG_KEY_LOW : ffeud_pkg::REG_KEY_HIGH, v);
            end
        end
        if ($urandom_range(0, 3) != 0) begin
            v = {$urandom(), $urandom()};
            case ($urandom_range(0, 7))
                0:       v[4:0] = 5'd0;
                1:       v[4:0] = 5'd16;
                2:       v[4:0] = 5'd31;
                3:       v[4:0] = 5'($urandom_range(17, 31));
                default: v[4:0] = 5'($urandom_range(1, 6));
            endcase
            write_reg(ffeud_pkg::REG_KEY_LEN, v);
        end
        if ($urandom_range(0, 3) != 0) begin
            v = {$urandom(), $urandom()};
            case ($urandom_range(0, 7))
                0:       v[7:0] = 8'd0;
                1:       v[7:0] = 8'd255;
                2:       v[7:0] = 8'd1;
                default: v[7:0] = 8'($urandom_range(1, 40));
            endcase
            write_reg(ffeud_pkg::REG_VAL_LIMIT, v);
        end
    endtask

    // mostly key=value&key=value bodies, some near-miss keys, some plain noise
    task automatic build_form_body();
        int nseg;
        int hit;
        int klen;
        int n;
        body_q.delete();
        klen = (int'(key_len_reg) > ffeud_pkg::KEY_BYTES_DEF) ?
               ffeud_pkg::KEY_BYTES_DEF : int'(key_len_reg);
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 10);
            repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        nseg = $urandom_range(1, 4);
        hit  = $urandom_range(0, nseg);
        for (int s = 0; s < nseg; s++) begin
            if (s != 0) body_q.push_back(ffeud_pkg::CH_AMP);
            if (s == hit || $urandom_range(0, 7) == 0) begin
                for (int k = 0; k < klen; k++) body_q.push_back(key_at(k));
                case ($urandom_range(0, 9))
                    0: body_q.push_back(pick_key_char());
                    1: if (klen != 0) void'(body_q.pop_back());
                    2: if (klen != 0) body_q[body_q.size()-1] = body_q[body_q.size()-1] ^ 8'h20;
                    default: ;
                endcase
            end else begin
                n = $urandom_range(0, 5);
                repeat (n) body_q.push_back(pick_key_char());
            end
            if ($urandom_range(0, 9) != 0) body_q.push_back(ffeud_pkg::CH_EQUAL);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
            repeat (n) begin
                case ($urandom_range(0, 11))
                    0, 1, 2, 3: body_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
                    4: body_q.push_back(ffeud_pkg::CH_PLUS);
                    5: begin
                        body_q.push_back(ffeud_pkg::CH_PERCENT);
                        body_q.push_back(pick_hex());
                        body_q.push_back(pick_hex());
                    end
                    6: begin
                        body_q.push_back(ffeud_pkg::CH_PERCENT);
                        body_q.push_back(pick_nonhex());
                    end
                    7: begin
                        body_q.push_back(ffeud_pkg::CH_PERCENT);
                        body_q.push_back(pick_hex());
                        body_q.push_back(pick_nonhex());
                    end
                    8:  body_q.push_back(8'($urandom_range(1, 255)));
                    9:  body_q.push_back(ffeud_pkg::CH_EQUAL);
                    10: body_q.push_back(8'($urandom_range(128, 255)));
                    default: body_q.push_back(pick_hex());
                endcase
            end
        end
        case ($urandom_range(0, 9))
            0: begin
                body_q.push_back(8'd0);
                n = $urandom_range(0, 4);
                repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
            end
            1: body_q.push_back(ffeud_pkg::CH_PERCENT);
            2: begin
                body_q.push_back(ffeud_pkg::CH_PERCENT);
                body_q.push_back(pick_hex());
            end
            3: begin
                body_q.push_back(ffeud_pkg::CH_PERCENT);
                body_q.push_back(pick_hex());
                body_q.push_back(pick_nonhex());
            end
            default: ;
        endcase
        if (body_q.size() == 0) body_q.push_back(8'($urandom_range(1, 255)));
    endtask

    initial begin : result_monitor
        t_field_result want;
        int            stall;
        logic          quiet;
        quiet = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do begin
                @(posedge clk);
            end while (!m_tvalid);
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: kind %0d byte %02h len %0d last %0b",
                             m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser != want.kind || m_tdata[7:0] != want.vbyte ||
                    m_tdata[15:8] != want.vlen || m_tlast != want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"result mismatch: expected kind %0d byte %02h len %0d last %0b,",
                                  " got kind %0d byte %02h len %0d last %0b"},
                                 want.kind, want.vbyte, want.vlen, want.last,
                                 m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
                end
            end
        end
    end

    initial begin : stimulus
        t_plan_row plan[$];
        int        nbodies;
        reset_extractor();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty key, limit 32
        plan.push_back(byte_exp(8'h00, 1'b0, ffeud_pkg::KIND_ABSENT, 8'd0, 8'd0));
        plan.push_back(byte_row(8'hff, 1'b1));       // ignored after the end
        plan.push_back(byte_row("=", 1'b0));
        plan.push_back(byte_exp("A", 1'b0, ffeud_pkg::KIND_BYTE, "A", 8'd0));
        plan.push_back(byte_exp("+", 1'b0, ffeud_pkg::KIND_BYTE, ffeud_pkg::CH_SPACE, 8'd0));
        plan.push_back(byte_row("%", 1'b0));
        plan.push_back(byte_row("4", 1'b0));
        plan.push_back(byte_row("1", 1'b0));
        plan.push_back(byte_row("%", 1'b0));         // invalid escape, passes through
        plan.push_back(byte_row("G", 1'b0));
        plan.push_back(byte_row("%", 1'b0));         // broken escape on the last byte
        plan.push_back(byte_row("a", 1'b0));
        plan.push_back(byte_row("z", 1'b1));
        plan.push_back(byte_row("=", 1'b0));
        plan.push_back(byte_row("%", 1'b1));         // escape still pending at the end
        // key "a&b", zero limit
        plan.push_back(cfg_row(ffeud_pkg::REG_KEY_LOW, 64'hffff_ffff_ff62_2661));
        plan.push_back(cfg_row(ffeud_pkg::REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff));
        plan.push_back(cfg_row(ffeud_pkg::REG_KEY_LEN, 64'd3));
        plan.push_back(cfg_row(ffeud_pkg::REG_VAL_LIMIT, 64'd0));
        plan.push_back(cfg_row(REG_NONE, 64'hffff_ffff_ffff_ffff));
        plan.push_back(byte_row("a", 1'b0));
        plan.push_back(byte_row("&", 1'b0));
        plan.push_back(byte_row("b", 1'b0));
        plan.push_back(byte_exp("=", 1'b0, ffeud_pkg::KIND_FOUND, 8'd0, 8'd0));
        plan.push_back(byte_row(8'hff, 1'b1));
        // key length 31 acts as 16
        plan.push_back(cfg_row(ffeud_pkg::REG_KEY_LEN, 64'hffff_ffff_ffff_ffff));
        plan.push_back(byte_exp("=", 1'b1, ffeud_pkg::KIND_ABSENT, 8'd0, 8'd0));
        plan.push_back(cfg_row(ffeud_pkg::REG_KEY_LEN, 64'd0));
        plan.push_back(cfg_row(ffeud_pkg::REG_VAL_LIMIT, 64'hffff_ffff_ffff_ff01));
        plan.push_back(byte_row("=", 1'b0));
        plan.push_back(byte_row(8'hff, 1'b0));
        plan.push_back(byte_row("%", 1'b1));
        plan.push_back(cfg_row(ffeud_pkg::REG_VAL_LIMIT, 64'd255));
        plan.push_back(byte_row("=", 1'b0));
        plan.push_back(byte_exp(8'h00, 1'b1, ffeud_pkg::KIND_FOUND, 8'd0, 8'd0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_reg(plan[i].index, plan[i].data);
            else send_byte(plan[i]);
        end

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            pick_settings();
            nbodies = $urandom_range(2, 6);
            for (int b = 0; b < nbodies && sent_items < RANDOM_ITEMS; b++) begin
                build_form_body();
                foreach (body_q[k]) send_byte(byte_row(body_q[k], k == body_q.size() - 1));
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/ffeud_pkg.sv
design/ffeud_core.sv
design/ffeud_outq.sv
design/form_field_extract_url_decode.sv
design/ffeud_chk.sv
tb/form_field_extract_url_decode_tb.sv
